@@ rtl/tmsag_pkg.sv @@
// tmsag_pkg: shared types, widths and codes for the tile map sprite address generator
// no dependencies; imported by every module of the block

package tmsag_pkg;

    // field and register widths
    localparam int IDX_W      = 15;  // non-negative tile index bits
    localparam int TILE_W     = 16;  // signed tile index field
    localparam int ORG_W      = 16;  // signed origin fields
    localparam int SPR_W      = 9;   // sprite width and height
    localparam int MARGIN_W   = 8;   // margin and spacing
    localparam int COLS_W     = 11;  // sheet columns
    localparam int TILES_W    = 15;  // sheet tiles
    localparam int MAPC_W     = 13;  // map columns
    localparam int POS_W      = 12;  // map column and row position
    localparam int SRC_W      = 20;  // source coordinates
    localparam int DST_W      = 25;  // destination coordinates
    localparam int DSIZE_W    = 12;  // destination width and height
    localparam int STEP_W     = 10;  // sprite size plus spacing
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 15;

    // parameter defaults
    localparam int SCALE_DEF       = 2;
    localparam int MAX_MAP_DIM_DEF = 4096;

    // register reset values
    localparam logic [SPR_W-1:0]    SPRITE_W_RST = 9'd16;
    localparam logic [SPR_W-1:0]    SPRITE_H_RST = 9'd16;
    localparam logic [COLS_W-1:0]   SHEET_COLS_RST = 11'd1;
    localparam logic [TILES_W-1:0]  SHEET_TILES_RST = 15'd1;
    localparam logic [MAPC_W-1:0]   MAP_COLS_RST = 13'd1;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SPRITE_WIDTH  = 3'd0,
        CFG_SPRITE_HEIGHT = 3'd1,
        CFG_SHEET_MARGIN  = 3'd2,
        CFG_SHEET_SPACING = 3'd3,
        CFG_SHEET_COLUMNS = 3'd4,
        CFG_SHEET_TILES   = 3'd5,
        CFG_MAP_COLUMNS   = 3'd6
    } cfg_idx_t;

    // command status codes
    typedef enum logic [1:0] {
        STATUS_DRAW  = 2'd0,
        STATUS_EMPTY = 2'd1,
        STATUS_RANGE = 2'd2
    } tile_status_t;

    // sequencer states
    typedef enum logic [2:0] {
        SEQ_IDLE     = 3'd0,
        SEQ_DST_X    = 3'd1,
        SEQ_DST_Y    = 3'd2,
        SEQ_DIV_WAIT = 3'd3,
        SEQ_SRC_X    = 3'd4,
        SEQ_SRC_Y    = 3'd5,
        SEQ_FINISH   = 3'd6
    } seq_state_t;

    // divider status toward the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

endpackage

@@ rtl/tmsag_divider.sv @@
// tmsag_divider: restoring divider, one quotient bit per cycle
// depends on tmsag_pkg for widths and the status struct

module tmsag_divider (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic [tmsag_pkg::IDX_W-1:0]     dividend,
    input  logic [tmsag_pkg::COLS_W-1:0]    divisor,
    output tmsag_pkg::div_status_t          stat,
    output logic [tmsag_pkg::IDX_W-1:0]     quotient,
    output logic [tmsag_pkg::COLS_W-1:0]    remainder
);
    import tmsag_pkg::*;

    localparam int CNT_W = $clog2(IDX_W);
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(IDX_W - 1);

    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [IDX_W-1:0]    quo_reg, quo_next;
    logic [COLS_W-1:0]   rem_reg, rem_next;
    logic [COLS_W-1:0]   div_reg;

    logic [COLS_W:0]     shifted;
    logic [COLS_W+1:0]   diff;
    logic                fits;

    // trial subtraction of one step
    always_comb
    begin
        shifted = {rem_reg, quo_reg[IDX_W-1]};
        diff    = {1'b0, shifted} - {2'b00, div_reg};
        fits    = ~diff[COLS_W+1];
    end

    // step control and datapath next values
    always_comb
    begin
        busy_next  = busy_reg;
        done_next  = done_reg;
        count_next = count_reg;
        quo_next   = quo_reg;
        rem_next   = rem_reg;
        if (start)
        begin
            busy_next  = 1'b1;
            done_next  = 1'b0;
            count_next = '0;
            quo_next   = dividend;
            rem_next   = '0;
        end
        else if (busy_reg)
        begin
            quo_next = {quo_reg[IDX_W-2:0], fits};
            rem_next = fits ? diff[COLS_W-1:0] : shifted[COLS_W-1:0];
            if (count_reg == LAST_STEP)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                count_next = count_reg + 1'b1;
            end
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            busy_reg  <= busy_next;
            done_reg  <= done_next;
            count_reg <= count_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        if (start)
        begin
            div_reg <= divisor;
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

`ifndef SYNTH
    a_busy_done_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(busy_reg && done_reg))
        else $error("divider busy and done together");

    a_rem_below_div: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg && div_reg != '0 |-> rem_reg < div_reg)
        else $error("divider remainder not below divisor");
`endif

endmodule

@@ rtl/tmsag_mac.sv @@
// tmsag_mac: shared multiply-add unit, result = addend + mult_a * mult_b, wrapped
// depends on tmsag_pkg for widths

module tmsag_mac #(
    parameter int C_W = 12
) (
    input  logic [tmsag_pkg::DST_W-1:0]  addend,
    input  logic [tmsag_pkg::IDX_W-1:0]  mult_a,
    input  logic [C_W-1:0]               mult_b,
    output logic [tmsag_pkg::DST_W-1:0]  result
);
    import tmsag_pkg::*;

    localparam int PROD_W = IDX_W + C_W;

    logic [PROD_W-1:0] prod;

    // full-width product, then wrap at the accumulator width
    assign prod   = {{C_W{1'b0}}, mult_a} * {{IDX_W{1'b0}}, mult_b};
    assign result = addend + DST_W'(prod);

endmodule

@@ rtl/tile_map_sprite_address_generator.sv @@
// tile_map_sprite_address_generator: one draw command word per tile index word.
// a word is taken only while the sequencer is idle, so the next word waits for the
// 15-step sheet-column divider and the two source passes through the shared
// multiply-add unit. the output register lets the next word start while one waits.
// reset (rst_n, async low) clears the map position, the sequencer state, the output
// valid and loads the register defaults; no clearing pass.

module tile_map_sprite_address_generator #(
    parameter int SCALE       = tmsag_pkg::SCALE_DEF,
    parameter int MAX_MAP_DIM = tmsag_pkg::MAX_MAP_DIM_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // configuration port
    input  logic                                cfg_we,
    input  logic [tmsag_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [tmsag_pkg::CFG_DATA_W-1:0]    cfg_data,
    // input channel
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic signed [tmsag_pkg::TILE_W-1:0] tile_index,
    input  logic signed [tmsag_pkg::ORG_W-1:0]  origin_x,
    input  logic signed [tmsag_pkg::ORG_W-1:0]  origin_y,
    input  logic                                mirror,
    input  logic                                last_tile,
    // output channel
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [1:0]                          status,
    output logic [tmsag_pkg::SRC_W-1:0]         src_x,
    output logic [tmsag_pkg::SRC_W-1:0]         src_y,
    output logic [tmsag_pkg::SPR_W-1:0]         src_w,
    output logic [tmsag_pkg::SPR_W-1:0]         src_h,
    output logic signed [tmsag_pkg::DST_W-1:0]  dst_x,
    output logic signed [tmsag_pkg::DST_W-1:0]  dst_y,
    output logic [tmsag_pkg::DSIZE_W-1:0]       dst_w,
    output logic [tmsag_pkg::DSIZE_W-1:0]       dst_h,
    output logic                                flip,
    output logic                                last_command
);
    import tmsag_pkg::*;

    localparam int DW_W  = SPR_W + $clog2(SCALE);
    localparam int MAC_C = (DW_W > STEP_W) ? DW_W : STEP_W;
    localparam logic [MAPC_W-1:0] MAP_MAX = MAPC_W'(MAX_MAP_DIM);

    // configuration registers
    logic [SPR_W-1:0]    sprite_width_reg;
    logic [SPR_W-1:0]    sprite_height_reg;
    logic [MARGIN_W-1:0] sheet_margin_reg;
    logic [MARGIN_W-1:0] sheet_spacing_reg;
    logic [COLS_W-1:0]   sheet_columns_reg;
    logic [TILES_W-1:0]  sheet_tiles_reg;
    logic [MAPC_W-1:0]   map_columns_reg;

    // map position
    logic [POS_W-1:0]    map_col_pos_reg, map_col_pos_next;
    logic [POS_W-1:0]    map_row_pos_reg, map_row_pos_next;

    // sequencer
    seq_state_t          state_reg, state_next;
    logic                in_accept;
    logic                out_load;

    // working word
    logic [ORG_W-1:0]    ox_reg, oy_reg;
    logic [POS_W-1:0]    col_w_reg, row_w_reg;
    logic                mirror_w_reg, last_w_reg;
    tile_status_t        status_w_reg, status_in;
    logic [DST_W-1:0]    dx_reg, dy_reg, sx_reg, sy_reg;

    // output register
    logic                out_valid_reg, out_valid_next;
    tile_status_t        o_status_reg;
    logic [SRC_W-1:0]    o_src_x_reg, o_src_y_reg;
    logic [DST_W-1:0]    o_dst_x_reg, o_dst_y_reg;
    logic                o_flip_reg, o_last_reg;

    // derived sizes
    logic [DW_W-1:0]     dw, dh;
    logic [STEP_W-1:0]   step_x, step_y;
    logic [COLS_W-1:0]   cols_eff;
    logic [MAPC_W-1:0]   map_w_eff;
    logic [MAPC_W-1:0]   col_inc, row_inc;

    // shared unit operands
    logic [DST_W-1:0]    mac_addend, mac_result;
    logic [IDX_W-1:0]    mac_a;
    logic [MAC_C-1:0]    mac_b;

    // divider
    div_status_t         div_stat;
    logic [IDX_W-1:0]    div_quo;
    logic [COLS_W-1:0]   div_rem;

    assign in_accept = in_valid && !in_stall;
    assign in_stall  = (state_reg != SEQ_IDLE);

    // sizes and effective counts
    always_comb
    begin
        dw       = DW_W'(sprite_width_reg * SCALE);
        dh       = DW_W'(sprite_height_reg * SCALE);
        step_x   = {1'b0, sprite_width_reg} + {2'b00, sheet_spacing_reg};
        step_y   = {1'b0, sprite_height_reg} + {2'b00, sheet_spacing_reg};
        cols_eff = (sheet_columns_reg == '0) ? COLS_W'(1) : sheet_columns_reg;
        priority if (map_columns_reg == '0)
        begin
            map_w_eff = MAPC_W'(1);
        end
        else if (map_columns_reg > MAP_MAX)
        begin
            map_w_eff = MAP_MAX;
        end
        else
        begin
            map_w_eff = map_columns_reg;
        end
    end

    // tile classification
    always_comb
    begin
        priority if (tile_index[TILE_W-1])
        begin
            status_in = STATUS_EMPTY;
        end
        else if (tile_index[IDX_W-1:0] >= sheet_tiles_reg)
        begin
            status_in = STATUS_RANGE;
        end
        else
        begin
            status_in = STATUS_DRAW;
        end
    end

    // position advance after each accepted word
    always_comb
    begin
        col_inc          = {1'b0, map_col_pos_reg} + MAPC_W'(1);
        row_inc          = {1'b0, map_row_pos_reg} + MAPC_W'(1);
        map_col_pos_next = map_col_pos_reg;
        map_row_pos_next = map_row_pos_reg;
        if (in_accept)
        begin
            if (last_tile)
            begin
                map_col_pos_next = '0;
                map_row_pos_next = '0;
            end
            else if (col_inc >= map_w_eff)
            begin
                map_col_pos_next = '0;
                map_row_pos_next = (row_inc >= MAP_MAX) ? '0 : row_inc[POS_W-1:0];
            end
            else
            begin
                map_col_pos_next = col_inc[POS_W-1:0];
            end
        end
    end

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sprite_width_reg  <= SPRITE_W_RST;
            sprite_height_reg <= SPRITE_H_RST;
            sheet_margin_reg  <= '0;
            sheet_spacing_reg <= '0;
            sheet_columns_reg <= SHEET_COLS_RST;
            sheet_tiles_reg   <= SHEET_TILES_RST;
            map_columns_reg   <= MAP_COLS_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_SPRITE_WIDTH:  sprite_width_reg  <= cfg_data[SPR_W-1:0];
                CFG_SPRITE_HEIGHT: sprite_height_reg <= cfg_data[SPR_W-1:0];
                CFG_SHEET_MARGIN:  sheet_margin_reg  <= cfg_data[MARGIN_W-1:0];
                CFG_SHEET_SPACING: sheet_spacing_reg <= cfg_data[MARGIN_W-1:0];
                CFG_SHEET_COLUMNS: sheet_columns_reg <= cfg_data[COLS_W-1:0];
                CFG_SHEET_TILES:   sheet_tiles_reg   <= cfg_data[TILES_W-1:0];
                CFG_MAP_COLUMNS:   map_columns_reg   <= cfg_data[MAPC_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // sequencer next state and shared unit operand select
    always_comb
    begin
        state_next     = state_reg;
        out_load       = 1'b0;
        out_valid_next = out_valid_reg && out_stall;
        mac_addend     = {{(DST_W-ORG_W){ox_reg[ORG_W-1]}}, ox_reg};
        mac_a          = IDX_W'(col_w_reg);
        mac_b          = MAC_C'(dw);
        unique case (state_reg)
            SEQ_IDLE:
            begin
                if (in_accept)
                begin
                    state_next = SEQ_DST_X;
                end
            end
            SEQ_DST_X:
            begin
                state_next = SEQ_DST_Y;
            end
            SEQ_DST_Y:
            begin
                mac_addend = {{(DST_W-ORG_W){oy_reg[ORG_W-1]}}, oy_reg};
                mac_a      = IDX_W'(row_w_reg);
                mac_b      = MAC_C'(dh);
                state_next = SEQ_DIV_WAIT;
            end
            SEQ_DIV_WAIT:
            begin
                if (div_stat.done)
                begin
                    state_next = SEQ_SRC_X;
                end
            end
            SEQ_SRC_X:
            begin
                mac_addend = DST_W'(sheet_margin_reg);
                mac_a      = IDX_W'(div_rem);
                mac_b      = MAC_C'(step_x);
                state_next = SEQ_SRC_Y;
            end
            SEQ_SRC_Y:
            begin
                mac_addend = DST_W'(sheet_margin_reg);
                mac_a      = div_quo;
                mac_b      = MAC_C'(step_y);
                state_next = SEQ_FINISH;
            end
            SEQ_FINISH:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_load       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = SEQ_IDLE;
                end
            end
            default:
            begin
                state_next = SEQ_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= SEQ_IDLE;
            out_valid_reg   <= 1'b0;
            map_col_pos_reg <= '0;
            map_row_pos_reg <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            out_valid_reg   <= out_valid_next;
            map_col_pos_reg <= map_col_pos_next;
            map_row_pos_reg <= map_row_pos_next;
        end
    end

    // working word capture and shared unit results
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            ox_reg       <= origin_x;
            oy_reg       <= origin_y;
            col_w_reg    <= map_col_pos_reg;
            row_w_reg    <= map_row_pos_reg;
            mirror_w_reg <= mirror;
            last_w_reg   <= last_tile;
            status_w_reg <= status_in;
        end
        if (state_reg == SEQ_DST_X)
        begin
            dx_reg <= mac_result;
        end
        if (state_reg == SEQ_DST_Y)
        begin
            dy_reg <= mac_result;
        end
        if (state_reg == SEQ_SRC_X)
        begin
            sx_reg <= mac_result;
        end
        if (state_reg == SEQ_SRC_Y)
        begin
            sy_reg <= mac_result;
        end
    end

    // output word register, skipped tiles carry a zero source corner
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            o_status_reg <= status_w_reg;
            o_src_x_reg  <= (status_w_reg == STATUS_DRAW) ? sx_reg[SRC_W-1:0] : '0;
            o_src_y_reg  <= (status_w_reg == STATUS_DRAW) ? sy_reg[SRC_W-1:0] : '0;
            o_dst_x_reg  <= dx_reg;
            o_dst_y_reg  <= dy_reg;
            o_flip_reg   <= mirror_w_reg;
            o_last_reg   <= last_w_reg;
        end
    end

    // sheet column divider
    tmsag_divider u_divider (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (in_accept),
        .dividend  (tile_index[IDX_W-1:0]),
        .divisor   (cols_eff),
        .stat      (div_stat),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    // shared multiply-add unit
    tmsag_mac #(
        .C_W (MAC_C)
    ) u_mac (
        .addend (mac_addend),
        .mult_a (mac_a),
        .mult_b (mac_b),
        .result (mac_result)
    );

    // ports; sizes are configuration, which the user holds while words are in flight
    assign out_valid    = out_valid_reg;
    assign status       = o_status_reg;
    assign src_x        = o_src_x_reg;
    assign src_y        = o_src_y_reg;
    assign src_w        = sprite_width_reg;
    assign src_h        = sprite_height_reg;
    assign dst_x        = o_dst_x_reg;
    assign dst_y        = o_dst_y_reg;
    assign dst_w        = DSIZE_W'(dw);
    assign dst_h        = DSIZE_W'(dh);
    assign flip         = o_flip_reg;
    assign last_command = o_last_reg;

`ifndef SYNTH
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input taken while a word is in work");

    a_skip_zero_src: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && o_status_reg != STATUS_DRAW |-> o_src_x_reg == '0 && o_src_y_reg == '0)
        else $error("skipped tile with nonzero source corner");

    a_row_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        {1'b0, map_row_pos_reg} < MAP_MAX)
        else $error("map row beyond map limit");

    a_load_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> state_reg == SEQ_FINISH && div_stat.done)
        else $error("output loaded before the divider finished");
`endif

endmodule

@@ verif/tmsag_command_checker.sv @@
`timescale 1ns / 100ps
// tmsag_command_checker: watches the register port and both word channels of the
// tile map sprite address generator, predicts each draw command and compares it.
// depends on tmsag_pkg for widths, register indexes and status codes.

module tmsag_command_checker #(
    parameter int SCALE       = tmsag_pkg::SCALE_DEF,
    parameter int MAX_MAP_DIM = tmsag_pkg::MAX_MAP_DIM_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [tmsag_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [tmsag_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                                in_valid,
    input  logic                                in_stall,
    input  logic signed [tmsag_pkg::TILE_W-1:0] tile_index,
    input  logic signed [tmsag_pkg::ORG_W-1:0]  origin_x,
    input  logic signed [tmsag_pkg::ORG_W-1:0]  origin_y,
    input  logic                                mirror,
    input  logic                                last_tile,
    input  logic                                out_valid,
    input  logic                                out_stall,
    input  logic [1:0]                          status,
    input  logic [tmsag_pkg::SRC_W-1:0]         src_x,
    input  logic [tmsag_pkg::SRC_W-1:0]         src_y,
    input  logic [tmsag_pkg::SPR_W-1:0]         src_w,
    input  logic [tmsag_pkg::SPR_W-1:0]         src_h,
    input  logic signed [tmsag_pkg::DST_W-1:0]  dst_x,
    input  logic signed [tmsag_pkg::DST_W-1:0]  dst_y,
    input  logic [tmsag_pkg::DSIZE_W-1:0]       dst_w,
    input  logic [tmsag_pkg::DSIZE_W-1:0]       dst_h,
    input  logic                                flip,
    input  logic                                last_command,
    output int                                  fail_count,
    output int                                  pending
);

    import tmsag_pkg::*;

    // one predicted draw command word
    typedef struct packed {
        tile_status_t        status;
        logic [SRC_W-1:0]    src_x;
        logic [SRC_W-1:0]    src_y;
        logic [SPR_W-1:0]    src_w;
        logic [SPR_W-1:0]    src_h;
        logic [DST_W-1:0]    dst_x;
        logic [DST_W-1:0]    dst_y;
        logic [DSIZE_W-1:0]  dst_w;
        logic [DSIZE_W-1:0]  dst_h;
        logic                flip;
        logic                last_command;
    } draw_cmd_t;

    // shadow of the register file and the map position
    logic [SPR_W-1:0]    spr_w;
    logic [SPR_W-1:0]    spr_h;
    logic [MARGIN_W-1:0] margin;
    logic [MARGIN_W-1:0] spacing;
    logic [COLS_W-1:0]   sheet_cols;
    logic [TILES_W-1:0]  sheet_tiles;
    logic [MAPC_W-1:0]   map_cols;
    int                  col_pos;
    int                  row_pos;

    draw_cmd_t           cmd_queue[$];
    int                  errors;

    initial begin
        fail_count = 0;
        pending    = 0;
    end

    // effective map width: zero reads as one, capped at the map limit
    function automatic int map_width();
        if (map_cols == '0)
            return 1;
        if (int'(map_cols) > MAX_MAP_DIM)
            return MAX_MAP_DIM;
        return int'(map_cols);
    endfunction

    // source and destination rectangles for one tile word
    function automatic draw_cmd_t predict_command(logic [TILE_W-1:0] tile,
                                                  logic signed [ORG_W-1:0] ox,
                                                  logic signed [ORG_W-1:0] oy,
                                                  logic mir, logic lst);
        draw_cmd_t       c;
        longint unsigned cols;
        longint unsigned dw;
        longint unsigned dh;
        longint unsigned sx;
        longint unsigned sy;
        longint          dx;
        longint          dy;
        cols = (sheet_cols == '0) ? 1 : longint'(sheet_cols);
        dw = longint'(spr_w) * SCALE;
        dh = longint'(spr_h) * SCALE;
        sx = 0;
        sy = 0;
        if (tile[TILE_W-1]) begin
            c.status = STATUS_EMPTY;
        end
        else if (tile[IDX_W-1:0] >= sheet_tiles) begin
            c.status = STATUS_RANGE;
        end
        else begin
            c.status = STATUS_DRAW;
            sx = longint'(margin) + (longint'(tile) % cols) * (longint'(spr_w) + spacing);
            sy = longint'(margin) + (longint'(tile) / cols) * (longint'(spr_h) + spacing);
        end
        dx = longint'(ox) + longint'(col_pos) * longint'(dw);
        dy = longint'(oy) + longint'(row_pos) * longint'(dh);
        c.src_x = sx[SRC_W-1:0];
        c.src_y = sy[SRC_W-1:0];
        c.src_w = spr_w;
        c.src_h = spr_h;
        c.dst_x = dx[DST_W-1:0];
        c.dst_y = dy[DST_W-1:0];
        c.dst_w = dw[DSIZE_W-1:0];
        c.dst_h = dh[DSIZE_W-1:0];
        c.flip = mir;
        c.last_command = lst;
        return c;
    endfunction

    function automatic int field_diff(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
            return 1;
        end
        return 0;
    endfunction

    // register writes, command comparison, prediction
    always @(posedge clk or negedge rst_n) begin : track
        draw_cmd_t want;
        if (!rst_n) begin
            spr_w = SPRITE_W_RST;
            spr_h = SPRITE_H_RST;
            margin = '0;
            spacing = '0;
            sheet_cols = SHEET_COLS_RST;
            sheet_tiles = SHEET_TILES_RST;
            map_cols = MAP_COLS_RST;
            col_pos = 0;
            row_pos = 0;
            cmd_queue.delete();
        end
        else begin
            if (cfg_we) begin
                case (cfg_index)
                    CFG_SPRITE_WIDTH:  spr_w = cfg_data[SPR_W-1:0];
                    CFG_SPRITE_HEIGHT: spr_h = cfg_data[SPR_W-1:0];
                    CFG_SHEET_MARGIN:  margin = cfg_data[MARGIN_W-1:0];
                    CFG_SHEET_SPACING: spacing = cfg_data[MARGIN_W-1:0];
                    CFG_SHEET_COLUMNS: sheet_cols = cfg_data[COLS_W-1:0];
                    CFG_SHEET_TILES:   sheet_tiles = cfg_data[TILES_W-1:0];
                    CFG_MAP_COLUMNS:   map_cols = cfg_data[MAPC_W-1:0];
                    default: ;
                endcase
            end

            // command word leaves the block
            if (out_valid && !out_stall) begin
                if (cmd_queue.size() == 0) begin
                    $error("command word with no tile word pending");
                    errors++;
                end
                else begin
                    want = cmd_queue.pop_front();
                    errors += field_diff("status", want.status, status);
                    errors += field_diff("src_x", want.src_x, src_x);
                    errors += field_diff("src_y", want.src_y, src_y);
                    errors += field_diff("src_w", want.src_w, src_w);
                    errors += field_diff("src_h", want.src_h, src_h);
                    errors += field_diff("dst_x", want.dst_x, $unsigned(dst_x));
                    errors += field_diff("dst_y", want.dst_y, $unsigned(dst_y));
                    errors += field_diff("dst_w", want.dst_w, dst_w);
                    errors += field_diff("dst_h", want.dst_h, dst_h);
                    errors += field_diff("flip", want.flip, flip);
                    errors += field_diff("last_command", want.last_command, last_command);
                end
            end

            // tile word enters the block, then the map position moves on
            if (in_valid && !in_stall) begin
                cmd_queue.push_back(predict_command(tile_index, origin_x, origin_y,
                                                    mirror, last_tile));
                if (last_tile) begin
                    col_pos = 0;
                    row_pos = 0;
                end
                else begin
                    col_pos++;
                    if (col_pos >= map_width()) begin
                        col_pos = 0;
                        row_pos++;
                        if (row_pos >= MAX_MAP_DIM)
                            row_pos = 0;
                    end
                end
            end
        end
        fail_count <= errors;
        pending <= cmd_queue.size();
    end

endmodule

@@ verif/tile_map_sprite_address_generator_test.sv @@
`timescale 1ns / 100ps
// tile_map_sprite_address_generator_test: drives tile words and register settings into
// the address generator and gives the verdict; checking sits in tmsag_command_checker.
// depends on tmsag_pkg, the block itself and the checker.

module tile_map_sprite_address_generator_test;

    import tmsag_pkg::*;

    localparam int CYCLE_LIMIT = 1500000;
    localparam int DRAIN_WAIT  = 40;
    localparam int HOLD_SPAN   = 300;

    typedef enum {RX_RANDOM, RX_OPEN} rx_mode_t;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]    cfg_index = '0;
    logic [CFG_DATA_W-1:0]   cfg_data = '0;
    logic                    in_valid = 1'b0;
    logic                    in_stall;
    logic [TILE_W-1:0]       tile_index = '0;
    logic [ORG_W-1:0]        origin_x = '0;
    logic [ORG_W-1:0]        origin_y = '0;
    logic                    mirror = 1'b0;
    logic                    last_tile = 1'b0;
    logic                    out_valid;
    logic                    out_stall = 1'b0;
    logic [1:0]              status;
    logic [SRC_W-1:0]        src_x;
    logic [SRC_W-1:0]        src_y;
    logic [SPR_W-1:0]        src_w;
    logic [SPR_W-1:0]        src_h;
    logic signed [DST_W-1:0] dst_x;
    logic signed [DST_W-1:0] dst_y;
    logic [DSIZE_W-1:0]      dst_w;
    logic [DSIZE_W-1:0]      dst_h;
    logic                    flip;
    logic                    last_command;

    int                      fail_count;
    int                      pending;
    int unsigned             cycle_count = 0;
    int                      words_sent = 0;
    int                      settings_used = 0;
    int                      hold_requests = 0;
    int                      holds_served = 0;
    rx_mode_t                rx_mode = RX_RANDOM;
    logic [TILES_W-1:0]      cur_tiles = SHEET_TILES_RST;
    logic [MAPC_W-1:0]       cur_mapc = MAP_COLS_RST;

    // clock, 4 ns period
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    tile_map_sprite_address_generator dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .tile_index   (tile_index),
        .origin_x     (origin_x),
        .origin_y     (origin_y),
        .mirror       (mirror),
        .last_tile    (last_tile),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .status       (status),
        .src_x        (src_x),
        .src_y        (src_y),
        .src_w        (src_w),
        .src_h        (src_h),
        .dst_x        (dst_x),
        .dst_y        (dst_y),
        .dst_w        (dst_w),
        .dst_h        (dst_h),
        .flip         (flip),
        .last_command (last_command)
    );

    tmsag_command_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .tile_index   (tile_index),
        .origin_x     (origin_x),
        .origin_y     (origin_y),
        .mirror       (mirror),
        .last_tile    (last_tile),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .status       (status),
        .src_x        (src_x),
        .src_y        (src_y),
        .src_w        (src_w),
        .src_h        (src_h),
        .dst_x        (dst_x),
        .dst_y        (dst_y),
        .dst_w        (dst_w),
        .dst_h        (dst_h),
        .flip         (flip),
        .last_command (last_command),
        .fail_count   (fail_count),
        .pending      (pending)
    );

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d commands outstanding", cycle_count, pending);
            $display("FAILED: results differ");
            $finish;
        end
    end

    // receiver pacing: random stall runs, none in open mode, one long hold-off per request
    always
    begin : receiver_pacing
        int span;
        logic hold;
        @(posedge clk);
        if (hold_requests != holds_served)
        begin
            hold = 1'b1;
            span = HOLD_SPAN;
            holds_served++;
        end
        else if (rx_mode == RX_OPEN)
        begin
            hold = 1'b0;
            span = 1;
        end
        else
        begin
            hold = ($urandom_range(0, 2) == 0);
            if (hold)
                span = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 4);
            else
                span = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 8);
        end
        out_stall <= hold;
        repeat (span - 1) @(posedge clk);
    end

    // offer one tile word and wait until it is taken
    task automatic send_word(input logic [TILE_W-1:0] tile, input logic [ORG_W-1:0] ox,
                             input logic [ORG_W-1:0] oy, input logic mir, input logic lst);
        in_valid <= 1'b1;
        tile_index <= tile;
        origin_x <= ox;
        origin_y <= oy;
        mirror <= mir;
        last_tile <= lst;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        words_sent++;
    endtask

    task automatic pause_sender(input int n);
        if (n > 0)
        begin
            in_valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    // lower valid and wait until every predicted command has come out
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
    endtask

    // new register setting, only with the block idle
    task automatic apply_settings(input logic [CFG_DATA_W-1:0] sw, input logic [CFG_DATA_W-1:0] sh,
                                  input logic [CFG_DATA_W-1:0] mg, input logic [CFG_DATA_W-1:0] sp,
                                  input logic [CFG_DATA_W-1:0] cols,
                                  input logic [CFG_DATA_W-1:0] tiles,
                                  input logic [CFG_DATA_W-1:0] mapc);
        wait_drained();
        repeat (DRAIN_WAIT) @(posedge clk);
        write_reg(CFG_SPRITE_WIDTH, sw);
        write_reg(CFG_SPRITE_HEIGHT, sh);
        write_reg(CFG_SHEET_MARGIN, mg);
        write_reg(CFG_SHEET_SPACING, sp);
        write_reg(CFG_SHEET_COLUMNS, cols);
        write_reg(CFG_SHEET_TILES, tiles);
        write_reg(CFG_MAP_COLUMNS, mapc);
        cfg_we <= 1'b0;
        @(posedge clk);
        cur_tiles = tiles[TILES_W-1:0];
        cur_mapc = mapc[MAPC_W-1:0];
        settings_used++;
    endtask

    // sender gap: mostly none, some short, a few long
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        if (r < 95)
            return $urandom_range(1, 4);
        return $urandom_range(20, 60);
    endfunction

    // mostly valid sheet indices, then empty, out of range and raw words
    function automatic logic [TILE_W-1:0] pick_tile();
        logic [TILE_W-1:0] t;
        int r;
        r = $urandom_range(0, 9);
        t = $urandom;
        if (r < 7 && cur_tiles != '0)
            t = $urandom_range(int'(cur_tiles) - 1, 0);
        else if (r == 7)
            t[TILE_W-1] = 1'b1;
        else if (r == 8)
            t = (cur_tiles == '1) ? {1'b0, {IDX_W{1'b1}}} : $urandom_range(32767, int'(cur_tiles));
        return t;
    endfunction

    function automatic logic [ORG_W-1:0] pick_origin();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return {1'b0, {(ORG_W-1){1'b1}}};
        if (r == 1)
            return {1'b1, {(ORG_W-1){1'b0}}};
        return $urandom;
    endfunction

    // whole maps in raster order with an occasional early last cell
    task automatic run_map_phase(input int n_words, input logic idle_on);
        int k;
        int map_pos;
        int map_len;
        int mw;
        logic lst;
        logic [ORG_W-1:0] ox;
        logic [ORG_W-1:0] oy;
        mw = (cur_mapc == '0) ? 1 : ((int'(cur_mapc) > MAX_MAP_DIM_DEF) ? MAX_MAP_DIM_DEF
                                                                       : int'(cur_mapc));
        map_pos = 0;
        map_len = 1;
        ox = '0;
        oy = '0;
        for (k = 0; k < n_words; k++)
        begin
            if (map_pos == 0)
            begin
                map_len = (mw <= 32) ? mw * $urandom_range(1, 3) : $urandom_range(1, 40);
                ox = pick_origin();
                oy = pick_origin();
            end
            lst = (map_pos == map_len - 1) || ($urandom_range(0, 24) == 0);
            send_word(pick_tile(), ox, oy, $urandom_range(0, 1), lst);
            map_pos = lst ? 0 : map_pos + 1;
            if (idle_on)
                pause_sender(gap_len());
        end
    endtask

    // walk with no last cell, so the position only moves forward
    task automatic run_long_walk(input int n_words);
        int k;
        for (k = 0; k < n_words; k++)
            send_word(pick_tile(), $urandom, $urandom, $urandom_range(0, 1), 1'b0);
    endtask

    initial
    begin : stimulus
        int p;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // small sheet, 10 sprites in 4 columns, 3-wide map
        apply_settings(16, 8, 3, 2, 4, 10, 3);
        send_word(0, 16'h0000, 16'h0000, 1'b0, 1'b0);
        send_word(3, 16'h7fff, 16'h8000, 1'b1, 1'b0);
        send_word(4, 16'h8000, 16'h7fff, 1'b0, 1'b0);
        send_word(9, 16'h0010, 16'hfff0, 1'b1, 1'b0);
        send_word(10, 16'h0010, 16'hfff0, 1'b0, 1'b0);
        send_word(16'h7fff, 16'h0010, 16'hfff0, 1'b1, 1'b0);
        send_word(16'hffff, 16'h0010, 16'hfff0, 1'b0, 1'b0);
        send_word(16'h8000, 16'h0010, 16'hfff0, 1'b1, 1'b0);
        send_word(5, 16'h0010, 16'hfff0, 1'b0, 1'b1);
        send_word(1, 16'hffff, 16'h0001, 1'b0, 1'b0);
        send_word(2, 16'hffff, 16'h0001, 1'b1, 1'b1);

        // zero sheet and map columns read as one, 256x256 sprites, margin and spacing 255
        apply_settings(256, 256, 255, 255, 0, 100, 0);
        send_word(7, 16'h7fff, 16'h7fff, 1'b0, 1'b0);
        send_word(99, 16'h7fff, 16'h7fff, 1'b1, 1'b0);
        send_word(100, 16'h7fff, 16'h7fff, 1'b0, 1'b0);
        send_word(16'hfffb, 16'h7fff, 16'h7fff, 1'b1, 1'b1);

        // empty sheet: every non-negative index out of range; oversized map width is capped
        apply_settings(1, 1, 0, 0, 1024, 0, 8191);
        send_word(0, 16'h8000, 16'h8000, 1'b0, 1'b0);
        send_word(16'h7fff, 16'h8000, 16'h8000, 1'b1, 1'b0);
        send_word(16'h8000, 16'h8000, 16'h8000, 1'b0, 1'b1);

        // random maps over minimum, maximum, in-range and raw register settings
        for (p = 0; p < 8; p++)
        begin
            case (p % 4)
                0: apply_settings(1, 1, 0, 0, 1, 1, 1);
                1: apply_settings(256, 256, 255, 255, 1024, 32767, 4096);
                2: apply_settings($urandom_range(1, 256), $urandom_range(1, 256),
                                  $urandom_range(0, 255), $urandom_range(0, 255),
                                  $urandom_range(1, 1024), $urandom_range(1, 32767),
                                  $urandom_range(1, 12));
                default: apply_settings($urandom, $urandom, $urandom, $urandom,
                                        $urandom, $urandom, $urandom);
            endcase
            rx_mode = (p == 5) ? RX_OPEN : RX_RANDOM;
            run_map_phase(80, p != 5);
            rx_mode = RX_RANDOM;

            // receiver holds off while words keep coming, then the sender drains
            if (p == 1)
            begin
                hold_requests++;
                run_map_phase(16, 1'b0);
                wait_drained();
            end
        end

        // one-wide map: the row moves on with every word
        apply_settings(256, 256, 7, 1, 33, 2000, 0);
        rx_mode = RX_OPEN;
        run_long_walk(60);

        // capped map width: the column keeps counting along one row
        apply_settings(200, 3, 0, 9, 5, 500, 8191);
        run_long_walk(60);
        rx_mode = RX_RANDOM;

        wait_drained();
        repeat (DRAIN_WAIT) @(posedge clk);
        $display("%0d tile words under %0d register settings, with full maps, skipped tiles,",
                 words_sent, settings_used);
        $display("column wrap at row ends, long walks, a receiver hold-off and random gaps");
        if (fail_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/tmsag_pkg.sv
rtl/tmsag_divider.sv
rtl/tmsag_mac.sv
rtl/tile_map_sprite_address_generator.sv
verif/tmsag_command_checker.sv
verif/tile_map_sprite_address_generator_test.sv
